// File: hdl/mhc_pkg.sv
// ----------------------------------------------------------------------------
// mhc_pkg
// Shared types, constants and tables of the magnetometer heading calibrator.
// ----------------------------------------------------------------------------
package mhc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SAMPLE_BITS  = 16;

    localparam int SW = 16;
    localparam int DW = SW + 1;
    localparam int CW = 26;
    localparam int ZW = 24;
    localparam int HW = 15;
    localparam int TW = 16;
    localparam int AW = 21;
    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam int FULL_TURN = 23040;
    localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(4 * 737280);
    localparam logic signed [ZW-1:0] Z_ROUND     = ZW'(128);

    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_CALIB   = 2'd1;
    localparam logic [1:0] KIND_HEADING = 2'd2;

    localparam logic [1:0] ST_HEADING   = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_CAL_DONE  = 2'd2;

    localparam int CIW = 1;
    localparam logic [CIW-1:0] CFG_THRESHOLD   = 1'd0;
    localparam logic [CIW-1:0] CFG_DECLINATION = 1'd1;

    localparam logic signed [SW-1:0] OFFSET_X_RST = -16'sd441;
    localparam logic signed [SW-1:0] OFFSET_Y_RST = 16'sd171;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 data_ready;
        logic signed [SW-1:0] sample_x;
        logic signed [SW-1:0] sample_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [HW-1:0]        heading_deg;
        logic signed [SW-1:0] center_x;
        logic signed [SW-1:0] center_y;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic track;
        logic center;
    } t_cal_ctl;

    function automatic logic [AW-1:0] atan_lut(input logic [4:0] idx);
        logic [AW-1:0] v;
        unique case (idx)
            5'd0:    v = AW'(737280);
            5'd1:    v = AW'(435242);
            5'd2:    v = AW'(229970);
            5'd3:    v = AW'(116736);
            5'd4:    v = AW'(58595);
            5'd5:    v = AW'(29326);
            5'd6:    v = AW'(14667);
            5'd7:    v = AW'(7334);
            5'd8:    v = AW'(3667);
            5'd9:    v = AW'(1833);
            5'd10:   v = AW'(917);
            5'd11:   v = AW'(458);
            5'd12:   v = AW'(229);
            5'd13:   v = AW'(115);
            5'd14:   v = AW'(57);
            5'd15:   v = AW'(29);
            5'd16:   v = AW'(14);
            5'd17:   v = AW'(7);
            5'd18:   v = AW'(4);
            5'd19:   v = AW'(2);
            5'd20:   v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [SW-1:0] sext_sample(input logic [SW-1:0] v);
        logic [SW-1:0] t;
        t = v << (SW - SAMPLE_BITS);
        return $signed(t) >>> (SW - SAMPLE_BITS);
    endfunction

endpackage

// File: hdl/mhc_stream_if.sv
// ----------------------------------------------------------------------------
// mhc_stream_if
// Valid/ready channels carrying sample items in and result items out.
// ----------------------------------------------------------------------------
interface mhc_in_if;
    import mhc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface mhc_out_if;
    import mhc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hdl/mhc_cal.sv
// ----------------------------------------------------------------------------
// mhc_cal
// Hard-iron min/max trackers and per-axis offsets.
// ----------------------------------------------------------------------------
module mhc_cal (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mhc_pkg::t_cal_ctl             i_ctl,
    input  logic signed [mhc_pkg::SW-1:0] i_sx,
    input  logic signed [mhc_pkg::SW-1:0] i_sy,
    input  logic [mhc_pkg::TW-1:0]        i_threshold,
    output logic signed [mhc_pkg::SW-1:0] o_offset_x,
    output logic signed [mhc_pkg::SW-1:0] o_offset_y
);
    import mhc_pkg::*;

    logic signed [SW-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic signed [SW-1:0] r_offset_x, r_offset_y;
    logic signed [DW-1:0] x_span, y_span, x_sum, y_sum, thr;

    assign x_span = {r_x_high[SW-1], r_x_high} - {r_x_low[SW-1], r_x_low};
    assign y_span = {r_y_high[SW-1], r_y_high} - {r_y_low[SW-1], r_y_low};
    assign x_sum  = {r_x_high[SW-1], r_x_high} + {r_x_low[SW-1], r_x_low};
    assign y_sum  = {r_y_high[SW-1], r_y_high} + {r_y_low[SW-1], r_y_low};
    assign thr    = {1'b0, i_threshold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low    <= '0;
            r_x_high   <= '0;
            r_y_low    <= '0;
            r_y_high   <= '0;
            r_offset_x <= OFFSET_X_RST;
            r_offset_y <= OFFSET_Y_RST;
        end else if (i_ctl.clear) begin
            r_x_low    <= '0;
            r_x_high   <= '0;
            r_y_low    <= '0;
            r_y_high   <= '0;
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_ctl.track) begin
            if (i_sx > r_x_high) r_x_high <= i_sx;
            if (i_sx < r_x_low)  r_x_low  <= i_sx;
            if (i_sy > r_y_high) r_y_high <= i_sy;
            if (i_sy < r_y_low)  r_y_low  <= i_sy;
        end else if (i_ctl.center) begin
            if (x_span > thr) r_offset_x <= x_sum[DW-1:1];
            if (y_span > thr) r_offset_y <= y_sum[DW-1:1];
        end
    end

    assign o_offset_x = r_offset_x;
    assign o_offset_y = r_offset_y;

endmodule

// File: hdl/mhc_cordic.sv
// ----------------------------------------------------------------------------
// mhc_cordic
// Vectoring CORDIC: one micro-rotation per cycle, angle rounded to 1/64 deg.
// ----------------------------------------------------------------------------
module mhc_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [mhc_pkg::SW-1:0] i_sx,
    input  logic signed [mhc_pkg::SW-1:0] i_sy,
    input  logic signed [mhc_pkg::SW-1:0] i_offset_x,
    input  logic signed [mhc_pkg::SW-1:0] i_offset_y,
    output logic                          o_done,
    output logic [mhc_pkg::HW-1:0]        o_heading
);
    import mhc_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_ROT  = 3'b010,
        C_FIN  = 3'b100
    } t_cstate;

    localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

    t_cstate              r_state, n_state;
    logic [IW-1:0]        r_i;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [DW-1:0] dx, dy;
    logic signed [CW-1:0] x0, y0, x_sh, y_sh;
    logic signed [ZW-1:0] ang, z_rnd, z_sh;
    logic signed [HW:0]   h_raw, h_wrap;

    assign dx   = {i_sx[SW-1], i_sx} - {i_offset_x[SW-1], i_offset_x};
    assign dy   = {i_sy[SW-1], i_sy} - {i_offset_y[SW-1], i_offset_y};
    assign x0   = {{(CW-DW){dx[DW-1]}}, dx} <<< 6;
    assign y0   = {{(CW-DW){dy[DW-1]}}, dy} <<< 6;
    assign x_sh = r_x >>> r_i;
    assign y_sh = r_y >>> r_i;
    assign ang  = $signed({{(ZW-AW){1'b0}}, atan_lut(5'(r_i))});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = (dx == '0 && dy == '0) ? C_FIN : C_ROT;
            C_ROT:  if (r_i == LAST_STEP) n_state = C_FIN;
            C_FIN:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_i <= '0;
            if (dx == '0 && dy == '0) begin
                r_z <= '0;
            end else if (dx[DW-1]) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= Z_HALF_TURN;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end else if (r_state == C_ROT) begin
            r_i <= r_i + 1'b1;
            if (r_y > 0) begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - ang;
            end
        end
    end

    assign z_rnd  = r_z + Z_ROUND;
    assign z_sh   = z_rnd >>> 8;
    assign h_raw  = z_sh[HW:0];
    assign h_wrap = (h_raw < 0) ? h_raw + (HW+1)'(FULL_TURN) : h_raw;

    assign o_done    = (r_state == C_FIN);
    assign o_heading = h_wrap[HW-1:0];

endmodule

// File: hdl/magnetometer_heading_calibrator_unit.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_calibrator_unit
// Hard-iron calibration and CORDIC atan2 heading for X/Y magnetometer samples.
// ----------------------------------------------------------------------------
// Each accepted item gives one result. A heading sample passes the decode,
// CORDIC, declination and done states before the output register, and the
// CORDIC rotation unit performs one micro-rotation per cycle; a calibration
// sample passes decode, center and done; any other item decode and done.
// Input ready is held low while an item is in work; the result waits in an
// output register, so the next item can be taken before it is consumed.
// Write configuration only while no item is in work.
module magnetometer_heading_calibrator_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    mhc_in_if.sink                  i_in,
    mhc_out_if.source               o_out,
    input  logic                    i_cfg_we,
    input  logic [mhc_pkg::CIW-1:0] i_cfg_idx,
    input  logic [mhc_pkg::TW-1:0]  i_cfg_data
);
    import mhc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_CENTER = 6'b000100,
        S_CORDIC = 6'b001000,
        S_DECL   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [TW-1:0]        r_threshold;
    logic signed [HW-1:0] r_decl;
    logic [1:0]           r_kind;
    logic                 r_rdy;
    logic signed [SW-1:0] r_sx, r_sy;
    logic [1:0]           r_status;
    logic [HW-1:0]        r_heading;
    logic [HW-1:0]        r_head_raw;
    logic                 r_ovalid;
    t_out_item            r_out;

    t_cal_ctl             cal_ctl;
    logic                 cordic_start, cordic_done;
    logic [HW-1:0]        cordic_heading;
    logic signed [SW-1:0] offset_x, offset_y;
    logic                 in_xact, out_free;
    logic signed [DW-1:0] decl_sum, decl_wrap;

    assign in_xact  = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_decl      <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_THRESHOLD) begin
                r_threshold <= i_cfg_data;
            end else if (i_cfg_idx == CFG_DECLINATION) begin
                r_decl <= $signed(i_cfg_data[HW-1:0]);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        cal_ctl      = '0;
        cordic_start = 1'b0;
        unique case (r_state)
            S_IDLE: if (in_xact) n_state = S_DECODE;
            S_DECODE: begin
                if (r_kind == KIND_CLEAR) begin
                    cal_ctl.clear = 1'b1;
                    n_state       = S_DONE;
                end else if (r_kind == KIND_CALIB && r_rdy) begin
                    cal_ctl.track = 1'b1;
                    n_state       = S_CENTER;
                end else if (r_kind == KIND_HEADING && r_rdy) begin
                    cordic_start = 1'b1;
                    n_state      = S_CORDIC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CENTER: begin
                cal_ctl.center = 1'b1;
                n_state        = S_DONE;
            end
            S_CORDIC: if (cordic_done) n_state = S_DECL;
            S_DECL:   n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_kind <= i_in.data.kind;
            r_rdy  <= i_in.data.data_ready;
            r_sx   <= sext_sample(i_in.data.sample_x);
            r_sy   <= sext_sample(i_in.data.sample_y);
        end
    end

    assign decl_sum  = $signed({2'b00, r_head_raw}) + {{(DW-HW){r_decl[HW-1]}}, r_decl};
    assign decl_wrap = (decl_sum < 0) ? decl_sum + DW'(FULL_TURN) :
                       (decl_sum >= DW'(FULL_TURN)) ? decl_sum - DW'(FULL_TURN) : decl_sum;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECODE) begin
            r_heading <= '0;
            if (r_kind == KIND_CLEAR || (r_kind == KIND_CALIB && r_rdy)) begin
                r_status <= ST_CAL_DONE;
            end else if (r_kind == KIND_HEADING && r_rdy) begin
                r_status <= ST_HEADING;
            end else begin
                r_status <= ST_NOT_READY;
            end
        end
        if (r_state == S_CORDIC && cordic_done) begin
            r_head_raw <= cordic_heading;
        end
        if (r_state == S_DECL) begin
            r_heading <= decl_wrap[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.status      <= r_status;
            r_out.heading_deg <= r_heading;
            r_out.center_x    <= offset_x;
            r_out.center_y    <= offset_y;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    mhc_cal u_cal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (cal_ctl),
        .i_sx        (r_sx),
        .i_sy        (r_sy),
        .i_threshold (r_threshold),
        .o_offset_x  (offset_x),
        .o_offset_y  (offset_y)
    );

    mhc_cordic u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cordic_start),
        .i_sx       (r_sx),
        .i_sy       (r_sy),
        .i_offset_x (offset_x),
        .i_offset_y (offset_y),
        .o_done     (cordic_done),
        .o_heading  (cordic_heading)
    );

    a_heading_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.status == ST_HEADING || o_out.data.heading_deg == '0))
        else $error("heading nonzero on a non-heading result");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.heading_deg < HW'(FULL_TURN)))
        else $error("heading outside one turn");

    a_cordic_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> (r_state == S_CORDIC))
        else $error("rotation unit finished outside its wait state");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact |=> !i_in.ready)
        else $error("input taken while an item is in work");

endmodule

// File: tb/tb_magnetometer_heading_calibrator_unit.sv
// ----------------------------------------------------------------------------
// tb_magnetometer_heading_calibrator_unit
// Self-checking bench for the hard-iron calibration and CORDIC heading unit.
// A scoreboard tracks min/max, offsets and registers, predicts each result
// (status, heading, centers) and compares in order. Directed corner items
// come first, then noisy calibration/heading runs under several threshold
// and declination settings; all but one add random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_magnetometer_heading_calibrator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mhc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 30;
    localparam int PHASE_ITEMS  = 85;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam longint ATAN_STEP [24] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0
    };

    class heading_scoreboard;
        logic signed [SW-1:0] x_low, x_high, y_low, y_high;
        logic signed [SW-1:0] offset_x, offset_y;
        logic [TW-1:0]        cal_threshold;
        logic signed [HW-1:0] declination;
        t_out_item            want_q[$];
        int unsigned          errors, checked;
        int unsigned          n_clear, n_calib, n_heading, n_skipped, n_settings;

        function new();
            x_low = '0; x_high = '0; y_low = '0; y_high = '0;
            offset_x = OFFSET_X_RST;
            offset_y = OFFSET_Y_RST;
            cal_threshold = '0;
            declination = '0;
        endfunction

        function void set_reg(logic [CIW-1:0] idx, logic [TW-1:0] value);
            if (idx == CFG_THRESHOLD) begin
                cal_threshold = value;
                n_settings++;
            end else begin
                declination = value[HW-1:0];
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void take_sample(t_in_item it);
            logic signed [SW-1:0] sx, sy;
            longint               cx, cy, nx, ny, z, h;
            int                   step;
            t_out_item            res;
            sx = it.sample_x << (SW - SAMPLE_BITS);
            sx = sx >>> (SW - SAMPLE_BITS);
            sy = it.sample_y << (SW - SAMPLE_BITS);
            sy = sy >>> (SW - SAMPLE_BITS);
            res.status = ST_NOT_READY;
            res.heading_deg = '0;
            case (it.kind)
                KIND_CLEAR: begin
                    x_low = '0; x_high = '0; y_low = '0; y_high = '0;
                    offset_x = '0; offset_y = '0;
                    res.status = ST_CAL_DONE;
                    n_clear++;
                end
                KIND_CALIB: begin
                    if (it.data_ready) begin
                        if (sx > x_high) x_high = sx;
                        if (sx < x_low) x_low = sx;
                        if (sy > y_high) y_high = sy;
                        if (sy < y_low) y_low = sy;
                        if (int'(x_high) - int'(x_low) > int'(cal_threshold))
                            offset_x = SW'((int'(x_high) + int'(x_low)) >>> 1);
                        if (int'(y_high) - int'(y_low) > int'(cal_threshold))
                            offset_y = SW'((int'(y_high) + int'(y_low)) >>> 1);
                        res.status = ST_CAL_DONE;
                        n_calib++;
                    end else begin
                        n_skipped++;
                    end
                end
                KIND_HEADING: begin
                    if (it.data_ready) begin
                        cx = (longint'(sx) - longint'(offset_x)) * 64;
                        cy = (longint'(sy) - longint'(offset_y)) * 64;
                        h = 0;
                        if (cx != 0 || cy != 0) begin
                            z = 0;
                            if (cx < 0) begin
                                cx = -cx;
                                cy = -cy;
                                z = 4 * ATAN_STEP[0];
                            end
                            for (step = 0; step < CORDIC_STEPS; step++) begin
                                if (cy > 0) begin
                                    nx = cx + (cy >>> step);
                                    ny = cy - (cx >>> step);
                                    z += ATAN_STEP[step];
                                end else begin
                                    nx = cx - (cy >>> step);
                                    ny = cy + (cx >>> step);
                                    z -= ATAN_STEP[step];
                                end
                                cx = nx;
                                cy = ny;
                            end
                            h = (z + 128) >>> 8;
                        end
                        h = (h + longint'(declination)) % FULL_TURN;
                        if (h < 0) h += FULL_TURN;
                        res.heading_deg = HW'(h);
                        res.status = ST_HEADING;
                        n_heading++;
                    end else begin
                        n_skipped++;
                    end
                end
                default: n_skipped++;
            endcase
            res.center_x = offset_x;
            res.center_y = offset_y;
            want_q.push_back(res);
        endfunction

        function void compare_result(t_out_item got);
            t_out_item want;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result: status %0d heading %0d center %0d,%0d",
                             $realtime, got.status, got.heading_deg, got.center_x,
                             got.center_y);
                return;
            end
            want = want_q.pop_front();
            checked++;
            if (got.status !== want.status || got.heading_deg !== want.heading_deg ||
                got.center_x !== want.center_x || got.center_y !== want.center_y) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch #%0d (exp/act): status %0d/%0d heading %0d/%0d %s",
                             $realtime, checked, want.status, got.status, want.heading_deg,
                             got.heading_deg, $sformatf("center_x %0d/%0d center_y %0d/%0d",
                             want.center_x, got.center_x, want.center_y, got.center_y));
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIW-1:0]    i_cfg_idx;
    logic [TW-1:0]     i_cfg_data;
    bit                idle_on;
    int unsigned       cycle_count;
    int unsigned       effective;
    heading_scoreboard heading_sb;

    mhc_in_if  in_bus();
    mhc_out_if out_bus();

    magnetometer_heading_calibrator_unit u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_bus),
        .o_out     (out_bus),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_bus.ready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready)
            heading_sb.compare_result(out_bus.data);
    end

    function automatic t_in_item make_item(logic [1:0] kind, logic ready,
                                           logic signed [SW-1:0] x, logic signed [SW-1:0] y);
        t_in_item it;
        it.kind = kind;
        it.data_ready = ready;
        it.sample_x = x;
        it.sample_y = y;
        return it;
    endfunction

    function automatic logic signed [SW-1:0] clamp_count(int v);
        if (v > 32767) return SW'(32767);
        if (v < -32768) return SW'(-32768);
        return SW'(v);
    endfunction

    task automatic send_item(input t_in_item it);
        while (idle_on && $urandom_range(99) < 16) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= it;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        heading_sb.take_sample(it);
        if (it.kind == KIND_CLEAR ||
            (it.data_ready && (it.kind == KIND_CALIB || it.kind == KIND_HEADING)))
            effective++;
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        in_bus.valid <= 1'b0;
        while (heading_sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic program_calibration(input logic [TW-1:0] thr, input int decl);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        heading_sb.set_reg(CFG_THRESHOLD, thr);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DECLINATION;
        i_cfg_data <= TW'(decl);
        @(posedge i_clk);
        heading_sb.set_reg(CFG_DECLINATION, TW'(decl));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // optionally clear, calibrate around a random center, then take headings there
    task automatic send_field_run();
        int cxc, cyc, rad, n_cal, n_head;
        cxc = int'($urandom_range(8000)) - 4000;
        cyc = int'($urandom_range(8000)) - 4000;
        rad = $urandom_range(40, 24000);
        n_cal = $urandom_range(2, 10);
        n_head = $urandom_range(2, 8);
        if ($urandom_range(1))
            send_item(make_item(KIND_CLEAR, 1'($urandom_range(1)), SW'($urandom()),
                                SW'($urandom())));
        repeat (n_cal)
            send_item(make_item(KIND_CALIB, $urandom_range(9) != 0,
                                clamp_count(cxc + int'($urandom_range(2 * rad)) - rad),
                                clamp_count(cyc + int'($urandom_range(2 * rad)) - rad)));
        repeat (n_head)
            send_item(make_item(KIND_HEADING, $urandom_range(9) != 0,
                                clamp_count(cxc + int'($urandom_range(2 * rad)) - rad),
                                clamp_count(cyc + int'($urandom_range(2 * rad)) - rad)));
    endtask

    initial begin
        t_in_item    directed[$];
        int          ph, target, decl;
        logic [TW-1:0] thr;
        heading_sb = new();
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.data = '0;
        out_bus.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{
            make_item(KIND_HEADING, 1'b1, 16'sd0, 16'sd0),
            make_item(KIND_HEADING, 1'b1, -16'sd441, 16'sd171),
            make_item(KIND_HEADING, 1'b0, 16'sd500, 16'sd500),
            make_item(KIND_CALIB, 1'b0, 16'sd9000, -16'sd9000),
            make_item(KIND_SPARE, 1'b1, 16'sd1234, 16'sd4321),
            make_item(KIND_HEADING, 1'b1, SW'(32767), SW'(32767)),
            make_item(KIND_HEADING, 1'b1, SW'(-32768), SW'(-32768)),
            make_item(KIND_HEADING, 1'b1, SW'(-32768), SW'(32767)),
            make_item(KIND_HEADING, 1'b1, SW'(32767), SW'(-32768)),
            make_item(KIND_CALIB, 1'b1, SW'(32767), SW'(-32768)),
            make_item(KIND_CALIB, 1'b1, SW'(-32768), SW'(32767)),
            make_item(KIND_HEADING, 1'b1, -16'sd1, -16'sd1),
            make_item(KIND_CLEAR, 1'b0, 16'sd77, -16'sd77),
            make_item(KIND_HEADING, 1'b1, 16'sd0, 16'sd0),
            make_item(KIND_HEADING, 1'b1, 16'sd100, 16'sd0),
            make_item(KIND_HEADING, 1'b1, 16'sd0, 16'sd100),
            make_item(KIND_HEADING, 1'b1, -16'sd100, 16'sd0),
            make_item(KIND_HEADING, 1'b1, 16'sd0, -16'sd100),
            make_item(KIND_HEADING, 1'b1, -16'sd100, -16'sd1),
            make_item(KIND_HEADING, 1'b1, -16'sd100, 16'sd1),
            make_item(KIND_CALIB, 1'b1, 16'sd5, 16'sd3),
            make_item(KIND_CALIB, 1'b1, -16'sd2, -16'sd7),
            make_item(KIND_CLEAR, 1'b1, 16'sd0, 16'sd0),
            make_item(KIND_CALIB, 1'b1, 16'sd0, 16'sd0)
        };
        foreach (directed[k]) send_item(directed[k]);
        wait_results_done();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin thr = 16'hFFFF; decl = 11520; end
                1: begin thr = '0; decl = -11520; end
                2: begin thr = TW'($urandom_range(3000)); decl = int'($urandom_range(23040)) - 11520; end
                3: begin thr = TW'($urandom()); decl = int'($urandom_range(23040)) - 11520; end
                default: begin thr = TW'($urandom_range(20000)); decl = 0; end
            endcase
            idle_on = (ph != 2);
            program_calibration(thr, decl);
            target = effective + PHASE_ITEMS;
            while (effective < target) begin
                if ($urandom_range(99) < 80)
                    send_field_run();
                else
                    send_item(make_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                                        SW'($urandom()), SW'($urandom())));
            end
            wait_results_done();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Checked %0d results: %0d headings, %0d calibration, %0d clears, %0d skipped",
                 heading_sb.checked, heading_sb.n_heading, heading_sb.n_calib,
                 heading_sb.n_clear, heading_sb.n_skipped);
        $display("Register settings applied: %0d, mismatches: %0d", heading_sb.n_settings,
                 heading_sb.errors);
        if (heading_sb.errors == 0 && heading_sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
